>>> src/voxel_frame_buffer_engine_assert.svh
// Assertion macros used by the voxel frame buffer engine back end.
`ifndef VOXEL_FRAME_BUFFER_ENGINE_ASSERT_SVH
`define VOXEL_FRAME_BUFFER_ENGINE_ASSERT_SVH
// Implication checked on every rising clock edge outside of reset.
`define VFB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside of reset.
`define VFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> src/vfb_pkg.sv
// Package with types, opcodes and voxel remap functions of the voxel frame buffer engine.
package vfb_pkg;
  localparam int EDGE = 4;
  localparam int NVOX = EDGE * EDGE * EDGE;
  localparam int CW = $clog2(EDGE);
  localparam int QDEPTH = 2;

  typedef logic [NVOX-1:0] plane_t;
  typedef plane_t [3:0] frame_t;

  typedef enum logic [4:0] {
    OP_VOXEL = 5'd0, OP_XLINE = 5'd1, OP_YLINE = 5'd2, OP_ZLINE = 5'd3,
    OP_XLAYER = 5'd4, OP_YLAYER = 5'd5, OP_ZLAYER = 5'd6, OP_ALL = 5'd7,
    OP_SHXP = 5'd8, OP_SHXN = 5'd9, OP_SHYP = 5'd10, OP_SHYN = 5'd11,
    OP_SHZP = 5'd12, OP_SHZN = 5'd13, OP_ROTX = 5'd14, OP_ROTY = 5'd15,
    OP_ROTZ = 5'd16, OP_MIRX = 5'd17, OP_MIRY = 5'd18, OP_MIRZ = 5'd19,
    OP_INVERT = 5'd20, OP_DIM = 5'd21, OP_BOX = 5'd22, OP_SHOW = 5'd23
  } opcode_t;

  // Remap kinds for the permutation unit.
  typedef enum logic [3:0] {
    RK_NONE, RK_MX, RK_MY, RK_MZ, RK_RX, RK_RY, RK_RZ,
    RK_SXP, RK_SXN, RK_SYP, RK_SYN, RK_SZP, RK_SZN
  } rkind_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [4:0] op;
    logic [3:0] xs, xe, ys, ye, zs, ze;
    logic [3:0] level;
    logic [4:0] amount;
    rkind_t     kind1;
    logic [1:0] turns1;
    rkind_t     kind2;
    logic [1:0] turns2;
    logic       mutate;
  } cmd_t;

  typedef enum logic [1:0] { BS_IDLE, BS_ROT, BS_EMIT } bstate_t;

  function automatic int bpos(input int x, input int y, input int z);
    return (y * EDGE + x) * EDGE + z;
  endfunction

  // One pass of a voxel permutation over all four planes.
  function automatic frame_t remap(input frame_t f, input rkind_t k);
    frame_t n;
    int sx, sy, sz;
    n = '0;
    for (int y = 0; y < EDGE; y++)
      for (int x = 0; x < EDGE; x++)
        for (int z = 0; z < EDGE; z++) begin
          sx = x; sy = y; sz = z;
          unique case (k)
            RK_MX: sx = EDGE - 1 - x;
            RK_MY: sy = EDGE - 1 - y;
            RK_MZ: sz = EDGE - 1 - z;
            RK_RX: begin sy = EDGE - 1 - z; sz = y; end
            RK_RY: begin sx = z; sz = EDGE - 1 - x; end
            RK_RZ: begin sx = EDGE - 1 - y; sy = x; end
            RK_SXP: sx = x - 1;
            RK_SXN: sx = x + 1;
            RK_SYP: sy = y - 1;
            RK_SYN: sy = y + 1;
            RK_SZP: sz = z - 1;
            RK_SZN: sz = z + 1;
            default: ;
          endcase
          if (sx >= 0 && sx < EDGE && sy >= 0 && sy < EDGE && sz >= 0 && sz < EDGE)
            for (int i = 0; i < 4; i++) n[i][bpos(x, y, z)] = f[i][bpos(sx, sy, sz)];
        end
    return n;
  endfunction
endpackage

>>> src/vfb_if.sv
// Valid/ready channel interfaces for commands and plane results.
interface vfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [4:0] opcode;
  logic signed [3:0] x_start, x_end, y_start, y_end, z_start, z_end;
  logic [3:0] level;
  logic [4:0] amount;
  modport source(output valid, opcode, x_start, x_end, y_start, y_end, z_start, z_end,
                 level, amount, input ready);
  modport sink(input valid, opcode, x_start, x_end, y_start, y_end, z_start, z_end,
               level, amount, output ready);
endinterface

interface vfb_plane_if;
  logic        valid;
  logic        ready;
  logic [1:0]  plane_index;
  logic [63:0] plane_bits;
  logic        last_plane;
  modport source(output valid, plane_index, plane_bits, last_plane, input ready);
  modport sink(input valid, plane_index, plane_bits, last_plane, output ready);
endinterface

>>> src/vfb_front.sv
// Command front end: accepts beats, decodes them and queues classified commands.
module vfb_front import vfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  vfb_cmd_if.sink    in_cmd,
  output logic       q_valid,
  output cmd_t       q_cmd,
  input  logic       q_pop
);
  cmd_t dec;
  cmd_t q_r [QDEPTH];
  logic [$clog2(QDEPTH+1)-1:0] cnt_r, cnt_nxt;
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic push;

  // Decode opcode into remap kinds and turn counts.
  always_comb begin
    dec = '0;
    dec.op = in_cmd.opcode;
    dec.xs = in_cmd.x_start; dec.xe = in_cmd.x_end;
    dec.ys = in_cmd.y_start; dec.ye = in_cmd.y_end;
    dec.zs = in_cmd.z_start; dec.ze = in_cmd.z_end;
    dec.level = in_cmd.level;
    dec.amount = in_cmd.amount;
    dec.kind1 = RK_NONE; dec.kind2 = RK_NONE;
    dec.mutate = 1'b1;
    priority case (in_cmd.opcode)
      OP_SHXP: begin dec.kind1 = RK_SXP; dec.turns1 = 2'd1; end
      OP_SHXN: begin dec.kind1 = RK_SXN; dec.turns1 = 2'd1; end
      OP_SHYP: begin dec.kind1 = RK_SYP; dec.turns1 = 2'd1; end
      OP_SHYN: begin dec.kind1 = RK_SYN; dec.turns1 = 2'd1; end
      OP_SHZP: begin dec.kind1 = RK_SZP; dec.turns1 = 2'd1; end
      OP_SHZN: begin dec.kind1 = RK_SZN; dec.turns1 = 2'd1; end
      OP_ROTX: begin dec.kind1 = RK_RX; dec.turns1 = in_cmd.amount[1:0]; end
      OP_ROTY: begin dec.kind1 = RK_RY; dec.turns1 = in_cmd.amount[1:0]; end
      OP_ROTZ: begin dec.kind1 = RK_RZ; dec.turns1 = in_cmd.amount[1:0]; end
      OP_MIRX: begin dec.kind1 = RK_MX; dec.turns1 = 2'd1; end
      OP_MIRY: begin dec.kind1 = RK_MY; dec.turns1 = 2'd1; end
      OP_MIRZ: begin dec.kind1 = RK_MZ; dec.turns1 = 2'd1; end
      OP_SHOW: begin
        dec.mutate = 1'b0;
        dec.turns2 = in_cmd.amount[1:0];
        unique case (in_cmd.amount[4:2])
          3'd0: dec.kind2 = RK_RY;
          3'd1: begin dec.kind1 = RK_RX; dec.turns1 = 2'd1; dec.kind2 = RK_RZ; end
          3'd2: begin dec.kind1 = RK_RX; dec.turns1 = 2'd2; dec.kind2 = RK_RY; end
          3'd3: begin dec.kind1 = RK_RX; dec.turns1 = 2'd3; dec.kind2 = RK_RZ; end
          3'd4: begin dec.kind1 = RK_RZ; dec.turns1 = 2'd1; dec.kind2 = RK_RX; end
          3'd5: begin dec.kind1 = RK_RZ; dec.turns1 = 2'd3; dec.kind2 = RK_RX; end
          default: dec.turns2 = 2'd0;
        endcase
      end
      default: ;
    endcase
    if (dec.kind1 == RK_NONE) dec.turns1 = 2'd0;
  end

  assign in_cmd.ready = (cnt_r != QDEPTH[$bits(cnt_r)-1:0]);
  assign push = in_cmd.valid && in_cmd.ready;
  assign q_valid = (cnt_r != '0);
  assign q_cmd = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 1'b1;
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= '0; rp_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
    end
  end
endmodule

>>> src/vfb_back.sv
// Command back end: updates the frame, runs rotations and emits the four planes.
module vfb_back import vfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  vfb_plane_if.source out_pl
);
  `include "voxel_frame_buffer_engine_assert.svh"

  frame_t frame_r, frame_nxt, work_r, work_nxt, drawn;
  cmd_t cmd_r, cmd_nxt;
  bstate_t st_r, st_nxt;
  logic phase_r, phase_nxt;
  logic [1:0] left_r, left_nxt, pidx_r, pidx_nxt;
  logic start;

  // Membership of a coordinate in a signed inclusive range.
  function automatic logic inr(input int c, input logic [3:0] s, input logic [3:0] e,
                               input int d);
    return (c >= $signed(s) + d) && (c <= $signed(e) - d);
  endfunction

  function automatic logic eqc(input int c, input logic [3:0] v);
    return c == $signed(v);
  endfunction

  // Per-voxel draw, fill and intensity update.
  always_comb begin
    logic hit;
    logic [3:0] v, nv;
    drawn = frame_r;
    for (int y = 0; y < EDGE; y++)
      for (int x = 0; x < EDGE; x++)
        for (int z = 0; z < EDGE; z++) begin
          hit = 1'b0;
          for (int i = 0; i < 4; i++) v[i] = frame_r[i][bpos(x, y, z)];
          nv = q_cmd.level;
          unique case (q_cmd.op)
            OP_VOXEL: hit = eqc(x, q_cmd.xs) && eqc(y, q_cmd.ys) && eqc(z, q_cmd.zs);
            OP_XLINE: hit = inr(x, q_cmd.xs, q_cmd.xe, 0) && eqc(y, q_cmd.ys)
                            && eqc(z, q_cmd.zs);
            OP_YLINE: hit = inr(y, q_cmd.ys, q_cmd.ye, 0) && eqc(x, q_cmd.xs)
                            && eqc(z, q_cmd.zs);
            OP_ZLINE: hit = inr(z, q_cmd.zs, q_cmd.ze, 0) && eqc(x, q_cmd.xs)
                            && eqc(y, q_cmd.ys);
            OP_XLAYER: hit = eqc(x, q_cmd.xs);
            OP_YLAYER: hit = eqc(y, q_cmd.ys);
            OP_ZLAYER: hit = eqc(z, q_cmd.zs);
            OP_ALL: hit = 1'b1;
            OP_INVERT: begin hit = 1'b1; nv = ~v; end
            OP_DIM: begin
              hit = 1'b1;
              nv = ({1'b0, v} >= q_cmd.amount) ? 4'(v - q_cmd.amount[3:0]) : 4'd0;
            end
            OP_BOX: hit =
              (inr(x, q_cmd.xs, q_cmd.xe, 0) && (eqc(y, q_cmd.ys) || eqc(y, q_cmd.ye))
               && (eqc(z, q_cmd.zs) || eqc(z, q_cmd.ze))) ||
              (inr(y, q_cmd.ys, q_cmd.ye, 1) && (eqc(x, q_cmd.xs) || eqc(x, q_cmd.xe))
               && (eqc(z, q_cmd.zs) || eqc(z, q_cmd.ze))) ||
              (inr(z, q_cmd.zs, q_cmd.ze, 1) && (eqc(x, q_cmd.xs) || eqc(x, q_cmd.xe))
               && (eqc(y, q_cmd.ys) || eqc(y, q_cmd.ye)));
            default: hit = 1'b0;
          endcase
          if (hit)
            for (int i = 0; i < 4; i++) drawn[i][bpos(x, y, z)] = nv[i];
        end
  end

  assign start = (st_r == BS_IDLE) && q_valid;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BS_IDLE: if (q_valid) st_nxt = BS_ROT;
      BS_ROT: if (left_r == 2'd0 && (phase_r || cmd_r.turns2 == 2'd0)) st_nxt = BS_EMIT;
      BS_EMIT: if (out_pl.ready && pidx_r == 2'd3) st_nxt = BS_IDLE;
      default: st_nxt = BS_IDLE;
    endcase
  end

  // Datapath updates: one remap pass per cycle in the rotate state.
  always_comb begin
    frame_nxt = frame_r; work_nxt = work_r; cmd_nxt = cmd_r;
    phase_nxt = phase_r; left_nxt = left_r; pidx_nxt = pidx_r;
    unique case (st_r)
      BS_IDLE: if (q_valid) begin
        cmd_nxt = q_cmd; frame_nxt = drawn; work_nxt = drawn;
        phase_nxt = 1'b0; left_nxt = q_cmd.turns1; pidx_nxt = 2'd0;
      end
      BS_ROT: begin
        if (left_r != 2'd0) begin
          work_nxt = remap(work_r, phase_r ? cmd_r.kind2 : cmd_r.kind1);
          left_nxt = left_r - 2'd1;
        end else if (!phase_r) begin
          phase_nxt = 1'b1; left_nxt = cmd_r.turns2;
        end
        if (st_nxt == BS_EMIT && cmd_r.mutate) frame_nxt = work_nxt;
      end
      BS_EMIT: if (out_pl.ready) pidx_nxt = pidx_r + 2'd1;
      default: ;
    endcase
  end

  // Outputs.
  always_comb begin
    q_pop = start;
    out_pl.valid = (st_r == BS_EMIT);
    out_pl.plane_index = pidx_r;
    out_pl.plane_bits = work_r[pidx_r];
    out_pl.last_plane = (pidx_r == 2'd3);
  end

  always_ff @(posedge clk) begin
    frame_r <= rst_n ? frame_nxt : '0;
    work_r <= work_nxt; cmd_r <= cmd_nxt; phase_r <= phase_nxt; left_r <= left_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BS_IDLE; pidx_r <= 2'd0;
    end else begin
      st_r <= st_nxt; pidx_r <= pidx_nxt;
    end
  end

  `VFB_ASSERT_IMPL(a_pop_idle, q_pop, st_r == BS_IDLE, "pop outside idle")
  `VFB_ASSERT_NEXT(a_emit_start, start, st_r == BS_ROT, "command did not start")
  `VFB_ASSERT_IMPL(a_last_idx, out_pl.valid && out_pl.last_plane, pidx_r == 2'd3,
                   "last flag on wrong plane")
  `VFB_ASSERT_NEXT(a_wrap, out_pl.valid && out_pl.ready && out_pl.last_plane,
                   st_r == BS_IDLE && pidx_r == 2'd0, "frame end not seen")
endmodule

>>> src/voxel_frame_buffer_engine.sv
// Top level of the voxel frame buffer engine.
// Keeps a 4x4x4 voxel cube with 4-bit intensity stored as four 64-bit bit planes.
// Command beats arrive on the in_ channel (valid/ready); each one draws, fills,
// shifts, rotates, mirrors, inverts, dims, draws a box or shows an orientation.
// For every command four result beats leave on the out_ channel, plane 0 first,
// with last_plane set on plane 3. Voxel (x,y,z) is bit y*16+x*4+z.
// Sequence: the draw is applied and the frame loaded, then the quarter-turn
// remap passes (0 to 6) run, a closing step ends the rotate state (with an extra
// step to switch between the two rotation steps of a shown orientation), and then
// the four planes are emitted.
// A two-entry command queue decouples the input from the back end, so commands
// are accepted while planes are still being sent.
// Reset (synchronous, rst_n low) clears the cube and empties the queue.
// When the receiver holds out_pl.ready low the current plane holds and the queue
// fills, after which in_cmd.ready drops.
module voxel_frame_buffer_engine import vfb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  vfb_cmd_if.sink     in_cmd,
  vfb_plane_if.source out_pl
);
  logic q_valid, q_pop;
  cmd_t q_cmd;

  vfb_front u_front (.clk, .rst_n, .in_cmd, .q_valid, .q_cmd, .q_pop);
  vfb_back  u_back  (.clk, .rst_n, .q_valid, .q_cmd, .q_pop, .out_pl);
endmodule
